// ===== design/stt_pkg.sv =====
package stt_pkg;

   localparam int POS_BITS = 16;
   localparam int KW_BUF_LEN = 6;
   localparam int KW_IDX_BITS = $clog2(KW_BUF_LEN);
   localparam int KW_COUNT = 7;
   localparam int QDEPTH = 4;
   localparam int QPTR_BITS = $clog2(QDEPTH);

   localparam logic [3:0] KIND_KEYWORD = 4'd0;
   localparam logic [3:0] KIND_IDENT = 4'd1;
   localparam logic [3:0] KIND_NUMBER = 4'd2;
   localparam logic [3:0] KIND_DOT = 4'd3;
   localparam logic [3:0] KIND_DDOT = 4'd4;
   localparam logic [3:0] KIND_COLON = 4'd5;
   localparam logic [3:0] KIND_DCOLON = 4'd6;
   localparam logic [3:0] KIND_COMMA = 4'd7;
   localparam logic [3:0] KIND_SYMBOL = 4'd8;
   localparam logic [3:0] KIND_DSYMBOL = 4'd9;
   localparam logic [3:0] KIND_SEMI = 4'd10;
   localparam logic [3:0] KIND_END = 4'd11;
   localparam logic [3:0] KIND_ERROR = 4'd12;

   localparam logic [2:0] KW_NONE = 3'd7;

   // Keyword text, first character in the lowest byte.
   localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
      48'h0000_636e_7566,
      48'h6c74_6e69_7270,
      48'h0000_7465_7265,
      48'h0000_0074_6572,
      48'h0000_0074_6e69,
      48'h0000_0072_7473,
      48'h0000_7261_6863
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd4, 3'd6, 3'd4, 3'd3, 3'd3, 3'd3, 3'd4};

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_WORD,
      MODE_NUMBER,
      MODE_DOT,
      MODE_COLON,
      MODE_SYMBOL
   } mode_type;

   typedef struct packed {
      logic [3:0] kind;
      logic [2:0] kw;
      logic [15:0] start;
      logic [7:0] len;
      logic [7:0] b0;
      logic [7:0] b1;
   } token_type;

   typedef struct packed {
      token_type t0;
      token_type t1;
      logic two;
   } record_type;

   function automatic logic is_space(logic [7:0] c);
      return c inside {8'h20, 8'h0a, 8'h09, 8'h0d};
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_word_char(logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == 8'h5f;
   endfunction

   function automatic logic is_pair_second(logic [7:0] c);
      return c inside {8'h26, 8'h2a, 8'h2b, 8'h2f, 8'h2d, 8'h3f, 8'h7c, 8'h25, 8'h3d,
                       8'h5e, 8'h21};
   endfunction

   function automatic logic is_symbol(logic [7:0] c);
      return is_pair_second(c) || (c inside {8'h28, 8'h29, 8'h7b, 8'h7d, 8'h5b, 8'h5d});
   endfunction

   function automatic token_type make_token(logic [3:0] kind, logic [2:0] kw,
                                            logic [15:0] start, logic [7:0] len,
                                            logic [7:0] b0, logic [7:0] b1);
      token_type t;
      t.kind = kind;
      t.kw = kw;
      t.start = start;
      t.len = len;
      t.b0 = b0;
      t.b1 = b1;
      return t;
   endfunction

   // Seven parallel comparators; a word longer than the buffer never matches.
   function automatic logic [2:0] keyword_lookup(logic [8*KW_BUF_LEN-1:0] wbuf,
                                                 logic [7:0] count, logic too_long);
      logic [2:0] r;
      logic hit;
      r = KW_NONE;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         hit = !too_long && (count == {5'd0, KW_LEN[k]});
         for (int j = 0; j < KW_BUF_LEN; j++) begin
            if ((3'(j) < KW_LEN[k]) && (wbuf[8*j +: 8] != KW_TEXT[k][8*j +: 8])) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            r = 3'(k);
         end
      end
      return r;
   endfunction

endpackage

// ===== design/source_text_tokenizer_unit.sv =====
// Source text tokenizer.
// The req_ channel carries one byte of text per transfer in req_tdata; a transfer
// with req_tuser high is the end marker, whose data byte is ignored.
// The rsp_ channel delivers one token per transfer, and rsp_tlast marks the last
// token caused by one input transfer.
// An input transfer is taken every cycle while the token queue has room.
// A byte yields zero, one or two tokens, and the end marker one or two.
// A token reaches rsp_ through the queue and the output register. The output
// channel gives one token per cycle while tokens wait and rsp_tready is high.
// The scanner holds one pending token as lookahead, so most tokens leave only
// when the byte after them arrives.
// When the receiver stalls, tokens wait in a four-entry queue, and req_tready
// drops only when that queue is full.
// An unknown byte yields an error token, after which input is taken and ignored.
// Reset is needed to leave that state.
// Reset clears the scanner, the queue and the output stage; no pass is needed.
module source_text_tokenizer_unit
   import stt_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,   // char_code
   input  logic req_tuser,         // end_marker
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [47:0] rsp_tdata,  // keyword_index, start_position, token_length,
                                   // first_byte, second_byte, then zero padding
   output logic [3:0] rsp_tuser,   // token_kind
   output logic rsp_tlast          // last_of_run
);

   logic q_full;
   logic q_push;
   record_type q_rec;
   logic q_pop;
   logic q_valid;
   record_type q_head;
   token_type tok;

   stt_front u_front (
      .clock(clock),
      .reset(reset),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .in_char(req_tdata),
      .in_end(req_tuser),
      .q_full(q_full),
      .q_push(q_push),
      .q_rec(q_rec)
   );

   stt_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_rec(q_rec),
      .full(q_full),
      .pop(q_pop),
      .head_valid(q_valid),
      .head_rec(q_head)
   );

   stt_back u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(q_valid),
      .head_rec(q_head),
      .pop(q_pop),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_tok(tok),
      .out_last(rsp_tlast)
   );

   assign rsp_tuser = tok.kind;
   assign rsp_tdata = {5'd0, tok.b1, tok.b0, tok.len, tok.start, tok.kw};

endmodule

// ===== design/stt_front.sv =====
module stt_front
   import stt_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [7:0] in_char,
   input  logic in_end,
   input  logic q_full,
   output logic q_push,
   output record_type q_rec
);

   mode_type mode_ff, mode_in;
   logic [POS_BITS-1:0] start_ff, start_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [7:0] count_ff, count_in;
   logic long_ff, long_in;
   logic [7:0] pend_ff, pend_in;
   logic halted_ff, halted_in;
   logic [7:0] wbuf_ff [KW_BUF_LEN];

   logic wb_we;
   logic [KW_IDX_BITS-1:0] wb_idx;
   logic [7:0] wb_data;
   logic [8*KW_BUF_LEN-1:0] wbuf_flat;
   logic take;
   logic a_v, b_v;
   logic consumed;
   token_type tok_a, tok_b, flush_tok;
   logic flush_v;
   logic [2:0] kw;
   logic [7:0] second;

   assign in_ready = !q_full;
   assign take = in_valid && in_ready;

   always_comb begin
      for (int i = 0; i < KW_BUF_LEN; i++) begin
         wbuf_flat[8*i +: 8] = wbuf_ff[i];
      end
   end

   always_comb begin
      kw = keyword_lookup(wbuf_flat, count_ff, long_ff);
      second = (count_ff >= 8'd2) ? wbuf_ff[1] : 8'd0;
      flush_v = (mode_ff != MODE_IDLE);
      case (mode_ff)
         MODE_WORD: begin
            flush_tok = make_token((kw == KW_NONE) ? KIND_IDENT : KIND_KEYWORD, kw,
                                   start_ff[15:0], count_ff, wbuf_ff[0], second);
         end
         MODE_NUMBER: begin
            flush_tok = make_token(KIND_NUMBER, KW_NONE, start_ff[15:0], count_ff,
                                   wbuf_ff[0], second);
         end
         MODE_DOT: begin
            flush_tok = make_token(KIND_DOT, KW_NONE, start_ff[15:0], 8'd1, 8'h2e, 8'd0);
         end
         MODE_COLON: begin
            flush_tok = make_token(KIND_COLON, KW_NONE, start_ff[15:0], 8'd1, 8'h3a, 8'd0);
         end
         MODE_SYMBOL: begin
            flush_tok = make_token(KIND_SYMBOL, KW_NONE, start_ff[15:0], 8'd1, pend_ff, 8'd0);
         end
         default: begin
            flush_tok = make_token(KIND_END, KW_NONE, start_ff[15:0], 8'd0, 8'd0, 8'd0);
         end
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      start_in = start_ff;
      pos_in = pos_ff;
      count_in = count_ff;
      long_in = long_ff;
      pend_in = pend_ff;
      halted_in = halted_ff;
      wb_we = 1'b0;
      wb_idx = count_ff[KW_IDX_BITS-1:0];
      wb_data = in_char;
      a_v = 1'b0;
      b_v = 1'b0;
      consumed = 1'b0;
      tok_a = flush_tok;
      tok_b = flush_tok;
      if (take && !halted_ff) begin
         if (in_end) begin
            a_v = flush_v;
            b_v = 1'b1;
            tok_b = make_token(KIND_END, KW_NONE, pos_ff[15:0], 8'd0, 8'd0, 8'd0);
            mode_in = MODE_IDLE;
         end else begin
            case (mode_ff)
               MODE_WORD: consumed = is_word_char(in_char);
               MODE_NUMBER: consumed = is_digit(in_char) || in_char == 8'h2e;
               MODE_DOT: begin
                  if (in_char == 8'h2e) begin
                     consumed = 1'b1;
                     a_v = 1'b1;
                     tok_a = make_token(KIND_DDOT, KW_NONE, start_ff[15:0], 8'd2,
                                        8'h2e, 8'h2e);
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_COLON: begin
                  if (in_char == 8'h3a) begin
                     consumed = 1'b1;
                     a_v = 1'b1;
                     tok_a = make_token(KIND_DCOLON, KW_NONE, start_ff[15:0], 8'd2,
                                        8'h3a, 8'h3a);
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_SYMBOL: begin
                  if (is_pair_second(in_char)) begin
                     consumed = 1'b1;
                     a_v = 1'b1;
                     tok_a = make_token(KIND_DSYMBOL, KW_NONE, start_ff[15:0], 8'd2,
                                        pend_ff, in_char);
                     mode_in = MODE_IDLE;
                  end
               end
               default: consumed = 1'b0;
            endcase

            if (consumed && (mode_ff == MODE_WORD || mode_ff == MODE_NUMBER)) begin
               if (count_ff < 8'(KW_BUF_LEN)) begin
                  wb_we = 1'b1;
               end else begin
                  long_in = 1'b1;
               end
               if (count_ff != 8'hff) begin
                  count_in = count_ff + 8'd1;
               end
            end

            if (!consumed) begin
               a_v = flush_v;
               mode_in = MODE_IDLE;
               if (is_space(in_char)) begin
                  mode_in = MODE_IDLE;
               end else if (is_alpha(in_char) || in_char == 8'h5f || is_digit(in_char)) begin
                  mode_in = is_digit(in_char) ? MODE_NUMBER : MODE_WORD;
                  start_in = pos_ff;
                  count_in = 8'd1;
                  long_in = 1'b0;
                  wb_we = 1'b1;
                  wb_idx = '0;
               end else if (in_char == 8'h2e) begin
                  mode_in = MODE_DOT;
                  start_in = pos_ff;
               end else if (in_char == 8'h3a) begin
                  mode_in = MODE_COLON;
                  start_in = pos_ff;
               end else if (in_char == 8'h2c) begin
                  b_v = 1'b1;
                  tok_b = make_token(KIND_COMMA, KW_NONE, pos_ff[15:0], 8'd1, in_char, 8'd0);
               end else if (is_symbol(in_char)) begin
                  mode_in = MODE_SYMBOL;
                  start_in = pos_ff;
                  pend_in = in_char;
               end else if (in_char == 8'h3b) begin
                  b_v = 1'b1;
                  tok_b = make_token(KIND_SEMI, KW_NONE, pos_ff[15:0], 8'd1, in_char, 8'd0);
               end else begin
                  b_v = 1'b1;
                  tok_b = make_token(KIND_ERROR, KW_NONE, pos_ff[15:0], 8'd1, in_char, 8'd0);
                  halted_in = 1'b1;
               end
            end
            pos_in = pos_ff + POS_BITS'(1);
         end
      end
   end

   always_comb begin
      q_push = a_v || b_v;
      q_rec.two = a_v && b_v;
      q_rec.t0 = a_v ? tok_a : tok_b;
      q_rec.t1 = tok_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         start_ff <= '0;
         pos_ff <= '0;
         count_ff <= '0;
         long_ff <= 1'b0;
         pend_ff <= '0;
         halted_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         start_ff <= start_in;
         pos_ff <= pos_in;
         count_ff <= count_in;
         long_ff <= long_in;
         pend_ff <= pend_in;
         halted_ff <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wb_we) begin
         wbuf_ff[wb_idx] <= wb_data;
      end
   end

endmodule

// ===== design/stt_queue.sv =====
module stt_queue
   import stt_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  record_type push_rec,
   output logic full,
   input  logic pop,
   output logic head_valid,
   output record_type head_rec
);

   record_type store_ff [QDEPTH];
   logic [QPTR_BITS-1:0] wptr_ff, wptr_in;
   logic [QPTR_BITS-1:0] rptr_ff, rptr_in;
   logic [QPTR_BITS:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full = (cnt_ff == (QPTR_BITS+1)'(QDEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_rec = store_ff[rptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && head_valid;

   always_comb begin
      wptr_in = do_push ? wptr_ff + QPTR_BITS'(1) : wptr_ff;
      rptr_in = do_pop ? rptr_ff + QPTR_BITS'(1) : rptr_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + (QPTR_BITS+1)'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - (QPTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wptr_ff] <= push_rec;
      end
   end

endmodule

// ===== design/stt_back.sv =====
module stt_back
   import stt_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic head_valid,
   input  record_type head_rec,
   output logic pop,
   output logic out_valid,
   input  logic out_ready,
   output token_type out_tok,
   output logic out_last
);

   record_type cur_ff, cur_in;
   logic busy_ff, busy_in;
   logic phase_ff, phase_in;
   logic done;

   assign out_valid = busy_ff;
   assign out_tok = phase_ff ? cur_ff.t1 : cur_ff.t0;
   assign out_last = phase_ff || !cur_ff.two;
   assign done = busy_ff && out_ready && out_last;
   assign pop = head_valid && (!busy_ff || done);

   always_comb begin
      cur_in = cur_ff;
      busy_in = busy_ff;
      phase_in = phase_ff;
      if (pop) begin
         cur_in = head_rec;
         busy_in = 1'b1;
         phase_in = 1'b0;
      end else if (busy_ff && out_ready) begin
         if (out_last) begin
            busy_in = 1'b0;
         end else begin
            phase_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule
